// ===== hdl/tlvcrc_pkg.sv =====
// types, codes and the crc-32 byte update shared by the tlv record checker
package tlvcrc_pkg;

  localparam int TAG_W  = 32;
  localparam int LEN_W  = 25;
  localparam int WORD_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [LEN_W-1:0]  REGION_RESET = 25'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TAG   = 1'd1;

  localparam logic [1:0] ST_CRC_OK   = 2'd0;
  localparam logic [1:0] ST_CRC_BAD  = 2'd1;
  localparam logic [1:0] ST_LEN_ERR  = 2'd2;
  localparam logic [1:0] ST_END      = 2'd3;

  typedef enum logic [3:0] {
    PH_TAG = 4'b0001,
    PH_LEN = 4'b0010,
    PH_VAL = 4'b0100,
    PH_CRC = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TAG_W-1:0] record_tag;
    logic [LEN_W-1:0] record_length;
    logic [1:0]       status;
    logic             tag_match;
  } res_t;

  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/tlvcrc_if.sv =====
// valid/ready channel interfaces for the input bytes and the record results
interface tlvcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tlvcrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] record_tag;
  logic [24:0] record_length;
  logic [1:0]  status;
  logic        tag_match;

  modport source (output valid, output record_tag, output record_length,
                  output status, output tag_match, input ready);
  modport sink (input valid, input record_tag, input record_length,
                input status, input tag_match, output ready);
endinterface

// ===== hdl/tlvcrc_parse.sv =====
// record walker: parse state, per-record crc and result decision for one byte
module tlvcrc_parse #(
  parameter int OFS_W = 26,
  parameter int CHK_W = 34
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  input  logic                     first_byte,
  input  logic [OFS_W-1:0]         region_limit,
  input  logic [31:0]              search_tag,
  output logic                     res_valid,
  output tlvcrc_pkg::res_t         res
);
  import tlvcrc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [OFS_W-1:0]  offset_r, offset_nxt;
  logic [OFS_W-1:0]  count_r, count_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [WORD_W-1:0] len_r, len_nxt;
  logic [WORD_W-1:0] crc_r, crc_nxt;
  logic [WORD_W-1:0] scrc_r, scrc_nxt;
  logic              halted_r, halted_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    count_nxt  = count_r;
    tag_nxt    = tag_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    scrc_nxt   = scrc_r;
    halted_nxt = halted_r;
    res_valid  = 1'b0;
    res        = '0;
    if (step) begin
      if (first_byte) begin
        phase_nxt  = PH_TAG;
        offset_nxt = '0;
        count_nxt  = '0;
        tag_nxt    = '0;
        len_nxt    = '0;
        crc_nxt    = ALL_ONES;
        scrc_nxt   = '0;
        halted_nxt = 1'b0;
      end
      if (!halted_nxt) begin
        case (phase_nxt)
          PH_TAG: begin
            if (count_nxt == '0 && offset_nxt >= region_limit) begin
              halted_nxt = 1'b1;
            end else begin
              tag_nxt    = {tag_nxt[TAG_W-9:0], data_byte};
              offset_nxt = offset_nxt + 1'b1;
              count_nxt  = count_nxt + 1'b1;
              if (count_nxt == OFS_W'(4)) begin
                count_nxt = '0;
                if (tag_nxt == ALL_ONES) begin
                  res_valid        = 1'b1;
                  res.record_tag   = tag_nxt;
                  res.status       = ST_END;
                  halted_nxt       = 1'b1;
                end else begin
                  len_nxt   = '0;
                  phase_nxt = PH_LEN;
                end
              end
            end
          end
          PH_LEN: begin
            len_nxt    = {len_nxt[WORD_W-9:0], data_byte};
            offset_nxt = offset_nxt + 1'b1;
            count_nxt  = count_nxt + 1'b1;
            if (count_nxt == OFS_W'(4)) begin
              count_nxt = '0;
              if (CHK_W'(offset_nxt) + CHK_W'(len_nxt) + CHK_W'(4) > CHK_W'(region_limit)) begin
                res_valid         = 1'b1;
                res.record_tag    = tag_nxt;
                res.record_length = len_nxt[LEN_W-1:0];
                res.status        = ST_LEN_ERR;
                halted_nxt        = 1'b1;
              end else begin
                crc_nxt   = ALL_ONES;
                scrc_nxt  = '0;
                phase_nxt = (len_nxt == '0) ? PH_CRC : PH_VAL;
              end
            end
          end
          PH_VAL: begin
            crc_nxt    = crc_byte(crc_nxt, data_byte);
            offset_nxt = offset_nxt + 1'b1;
            count_nxt  = count_nxt + 1'b1;
            if (count_nxt == len_nxt[OFS_W-1:0]) begin
              count_nxt = '0;
              phase_nxt = PH_CRC;
            end
          end
          PH_CRC: begin
            scrc_nxt   = {scrc_nxt[WORD_W-9:0], data_byte};
            offset_nxt = offset_nxt + 1'b1;
            count_nxt  = count_nxt + 1'b1;
            if (count_nxt == OFS_W'(4)) begin
              res_valid         = 1'b1;
              res.record_tag    = tag_nxt;
              res.record_length = len_nxt[LEN_W-1:0];
              res.status        = (scrc_nxt == ~crc_nxt) ? ST_CRC_OK : ST_CRC_BAD;
              res.tag_match     = (tag_nxt == search_tag);
              count_nxt         = '0;
              tag_nxt           = '0;
              phase_nxt         = PH_TAG;
            end
          end
          default: begin
            phase_nxt = PH_TAG;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      offset_r <= '0;
      count_r  <= '0;
      halted_r <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    len_r  <= len_nxt;
    crc_r  <= crc_nxt;
    scrc_r <= scrc_nxt;
  end

endmodule

// ===== hdl/tlv_record_crc_checker.sv =====
// tlv record walker with per-record crc-32 check, top level
// Takes one region byte per item, first_byte marking offset zero, and gives one result
// item at the end of each record (tag, length, crc status, search tag match), at a
// table end and at a length error; after an end, an error or the region end it drops
// bytes until the next first_byte. A byte passes an input register and one pass through
// the parser and the bytewise crc-32 update into a result register, and one byte is
// taken every cycle while the result side keeps up. Regions larger than
// 2^REGION_ADDR_BITS bytes are clipped to that size.
module tlv_record_crc_checker #(
  parameter int REGION_ADDR_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tlvcrc_in_if.sink                           in_ch,
  tlvcrc_out_if.source                        out_ch,
  input  logic                                cfg_wr_en,
  input  logic [tlvcrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlvcrc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import tlvcrc_pkg::*;

  localparam int LIM_W = (REGION_ADDR_BITS < LEN_W) ? REGION_ADDR_BITS + 1 : LEN_W;
  localparam int OFS_W = LIM_W + 1;
  localparam int CHK_W = ((OFS_W > WORD_W) ? OFS_W : WORD_W) + 2;
  localparam logic [CHK_W-1:0] REGION_CAP = CHK_W'(1) << REGION_ADDR_BITS;

  logic [LEN_W-1:0]  region_r;
  logic [TAG_W-1:0]  search_r;
  logic [CHK_W-1:0]  region_ext;
  logic [CHK_W-1:0]  limit_wide;

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_first_r;
  logic              s1_go;

  logic              res_valid;
  res_t              res;
  logic              out_valid_r;
  res_t              out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= REGION_RESET;
      search_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_REGION_BYTES: region_r <= cfg_wr_data[LEN_W-1:0];
        CFG_SEARCH_TAG:   search_r <= cfg_wr_data[TAG_W-1:0];
        default: ;
      endcase
    end
  end

  assign region_ext = CHK_W'(region_r);
  assign limit_wide = (region_ext > REGION_CAP) ? REGION_CAP : region_ext;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_first_r <= in_ch.first_byte;
    end
  end

  tlvcrc_parse #(
    .OFS_W (OFS_W),
    .CHK_W (CHK_W)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_go),
    .data_byte    (s1_byte_r),
    .first_byte   (s1_first_r),
    .region_limit (limit_wide[OFS_W-1:0]),
    .search_tag   (search_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.record_tag    = out_r.record_tag;
  assign out_ch.record_length = out_r.record_length;
  assign out_ch.status        = out_r.status;
  assign out_ch.tag_match     = out_r.tag_match;

endmodule

// ===== hdl/tlvcrc_chk.sv =====
// port-level checks on the result channel of the tlv record checker
module tlvcrc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_record_tag,
  input logic [24:0] out_record_length,
  input logic [1:0]  out_status,
  input logic        out_tag_match
);
  import tlvcrc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_record_tag)
      && $stable(out_record_length) && $stable(out_status) && $stable(out_tag_match))
    else $error("result item changed while stalled");

  a_match_only_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tag_match |-> out_status == ST_CRC_OK || out_status == ST_CRC_BAD)
    else $error("tag match on an end or length error item");

  a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_END |-> out_record_tag == ALL_ONES
      && out_record_length == '0)
    else $error("end of table item with bad tag or length");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind tlv_record_crc_checker tlvcrc_chk u_tlvcrc_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_record_tag    (out_ch.record_tag),
  .out_record_length (out_ch.record_length),
  .out_status        (out_ch.status),
  .out_tag_match     (out_ch.tag_match)
);
